// ===== rtl/encoder_window_velocity_filter_defines.svh =====
// assertion macros for the encoder window velocity filter
`ifndef ENCODER_WINDOW_VELOCITY_FILTER_DEFINES_SVH
`define ENCODER_WINDOW_VELOCITY_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define EWVF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define EWVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EWVF_ASSERT_IMPL(lbl, ante, cons, msg)
`define EWVF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ewvf_pkg.sv =====
// shared constants and types of the encoder window velocity filter
package ewvf_pkg;

  localparam int WINDOW    = 5;
  localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int DIV_STEPS = 32;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = 66;

  localparam logic [31:0] DEG_PER_COUNT_RST = 32'd1474560;
  localparam logic [2:0]  ALPHA_SHIFT_RST   = 3'd2;
  localparam logic [30:0] DEADBAND_RST      = 31'd32768;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    REG_DEG_PER_COUNT = 2'd0,
    REG_ALPHA_SHIFT   = 2'd1,
    REG_DEADBAND      = 2'd2
  } reg_idx_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIFF  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_SCALE = 9'b000001000,
    S_LOAD  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_AVG   = 9'b001000000,
    S_SNAP  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic        done;
    logic        big;
    logic [31:0] quot;
  } div_res_t;

endpackage

// ===== rtl/ewvf_ring.sv =====
// sample history ring: encoder count and timestamp per entry, registered read
module ewvf_ring (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ewvf_pkg::IDX_W-1:0] wr_idx,
  input  logic [31:0]                wr_pos,
  input  logic [31:0]                wr_time,
  input  logic [ewvf_pkg::IDX_W-1:0] rd_idx,
  output logic [31:0]                rd_pos,
  output logic [31:0]                rd_time
);

  logic [31:0] pos_r  [ewvf_pkg::WINDOW];
  logic [31:0] time_r [ewvf_pkg::WINDOW];
  logic [31:0] rd_pos_r;
  logic [31:0] rd_time_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_r[wr_idx]  <= wr_pos;
      time_r[wr_idx] <= wr_time;
    end
    rd_pos_r  <= pos_r[rd_idx];
    rd_time_r <= time_r[rd_idx];
  end

  assign rd_pos  = rd_pos_r;
  assign rd_time = rd_time_r;

endmodule

// ===== rtl/ewvf_div.sv =====
// serial restoring divider, one quotient bit per cycle, flags quotients of 2^32 and up
module ewvf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ewvf_pkg::NUM_W-1:0] num,
  input  logic [31:0]                den,
  output ewvf_pkg::div_res_t         res
);

  logic                        run_r;
  logic                        done_r;
  logic [ewvf_pkg::DCNT_W-1:0] cnt_r;
  logic                        big_r;
  logic [31:0]                 rem_r;
  logic [31:0]                 dvd_r;
  logic                        ovf;
  logic [32:0]                 trial;
  logic                        take;
  logic [32:0]                 diff;

  assign ovf   = num[ewvf_pkg::NUM_W-1:32] >= {2'b00, den};
  assign trial = {rem_r, dvd_r[31]};
  assign take  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        done_r <= ovf;
        if (ovf) begin
          run_r <= 1'b0;
        end else begin
          run_r <= 1'b1;
          cnt_r <= ewvf_pkg::DCNT_W'(ewvf_pkg::DIV_STEPS);
        end
      end else if (run_r) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == ewvf_pkg::DCNT_W'(1));
        if (cnt_r == ewvf_pkg::DCNT_W'(1)) begin
          run_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      big_r <= ovf;
      rem_r <= num[63:32];
      dvd_r <= num[31:0];
    end else if (run_r) begin
      rem_r <= take ? diff[31:0] : trial[31:0];
      dvd_r <= {dvd_r[30:0], take};
    end
  end

  assign res.done = done_r;
  assign res.big  = big_r;
  assign res.quot = dvd_r;

endmodule

// ===== rtl/encoder_window_velocity_filter.sv =====
// Encoder window velocity filter. Each sample beat stores count and timestamp in a
// five-entry history and, once two samples are held, turns the change against the
// oldest entry into deg/s (Q16.16), clips it to 32 bits and folds it into an
// exponential average with a zero-snap deadband; a flush beat clears history and
// velocity. One result beat per input beat. A sample that yields an estimate passes
// the states DIFF, MUL, SCALE, LOAD, DIV, AVG, SNAP and OUT in order; in DIV the
// 32-step serial divider divides by the elapsed milliseconds, or stops at once when
// the quotient reaches 2^32. A sample with fewer than two held or no elapsed time
// goes from DIFF to OUT, and a flush straight to OUT. Input is not ready while an
// item is in work and becomes ready as the result is registered; a finished result
// waits in the output register while the next beat is accepted.
`include "encoder_window_velocity_filter_defines.svh"

module encoder_window_velocity_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic signed [31:0]          in_encoder_count,
  input  logic [31:0]                 in_now_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_velocity,
  output logic                        out_updated,
  output logic                        out_saturated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ewvf_pkg::ADDR_W-1:0] paddr,
  input  logic [ewvf_pkg::DATA_W-1:0] pwdata,
  output logic [ewvf_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  ewvf_pkg::state_t             state_r;
  logic [ewvf_pkg::IDX_W-1:0]   wr_idx_r;
  logic [ewvf_pkg::IDX_W-1:0]   wr_idx_nxt;
  logic [ewvf_pkg::CNT_W-1:0]   fill_r;
  logic [ewvf_pkg::CNT_W-1:0]   fill_nxt;
  logic [31:0]                  avg_r;
  logic [31:0]                  deg_r;
  logic [2:0]                   alpha_r;
  logic [30:0]                  deadband_r;
  logic                         out_valid_r;

  logic [31:0]                  cnt_r;
  logic [31:0]                  now_r;
  logic                         neg_r;
  logic                         dzero_r;
  logic [31:0]                  m_r;
  logic [31:0]                  dt_r;
  logic [63:0]                  p_r;
  logic [ewvf_pkg::NUM_W-1:0]   num_r;
  logic [31:0]                  raw_r;
  logic                         sat_r;
  logic [31:0]                  avg_tmp_r;
  logic                         res_upd_r;
  logic                         res_sat_r;
  logic [31:0]                  out_velocity_r;
  logic                         out_updated_r;
  logic                         out_saturated_r;

  logic                         in_fire;
  logic                         out_free;
  logic                         cfg_wr;
  logic [ewvf_pkg::IDX_W-1:0]   rd_idx;
  logic [31:0]                  rd_pos;
  logic [31:0]                  rd_time;
  logic [31:0]                  d_now;
  logic [31:0]                  dt_now;
  logic [63:0]                  prod;
  logic [70:0]                  scaled;
  ewvf_pkg::div_res_t           div_res;
  logic [31:0]                  limit;
  logic                         clip;
  logic [31:0]                  q_clip;
  logic signed [32:0]           diff_s;
  logic signed [32:0]           sh_s;
  logic [31:0]                  avg_new;
  logic [31:0]                  mag;
  logic [31:0]                  avg_snap;

  assign in_ready  = (state_r == ewvf_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_velocity  = out_velocity_r;
  assign out_updated   = out_updated_r;
  assign out_saturated = out_saturated_r;

  always_comb begin
    case (paddr[3:2])
      ewvf_pkg::REG_DEG_PER_COUNT: prdata = deg_r;
      ewvf_pkg::REG_ALPHA_SHIFT:   prdata = {29'd0, alpha_r};
      ewvf_pkg::REG_DEADBAND:      prdata = {1'b0, deadband_r};
      default:                     prdata = '0;
    endcase
  end

  assign wr_idx_nxt = (wr_idx_r == ewvf_pkg::IDX_W'(ewvf_pkg::WINDOW - 1)) ?
                      '0 : wr_idx_r + 1'b1;
  assign fill_nxt   = (fill_r < ewvf_pkg::CNT_W'(ewvf_pkg::WINDOW)) ?
                      fill_r + 1'b1 : fill_r;
  // oldest entry read at acceptance via updated pointers; written slot only if ring is empty
  assign rd_idx     = (fill_nxt < ewvf_pkg::CNT_W'(ewvf_pkg::WINDOW)) ? '0 : wr_idx_nxt;

  ewvf_ring u_ring (
    .clk     (clk),
    .wr_en   (in_fire && (in_op == ewvf_pkg::OP_SAMPLE)),
    .wr_idx  (wr_idx_r),
    .wr_pos  (in_encoder_count),
    .wr_time (in_now_ms),
    .rd_idx  (rd_idx),
    .rd_pos  (rd_pos),
    .rd_time (rd_time)
  );

  assign d_now  = cnt_r - rd_pos;
  assign dt_now = now_r - rd_time;

  assign prod   = m_r * deg_r;
  // x1000 / 256 is x125 / 32
  assign scaled = ({7'd0, p_r} << 7) - ({7'd0, p_r} << 2) + {7'd0, p_r};

  ewvf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ewvf_pkg::S_LOAD),
    .num   (num_r),
    .den   (dt_r),
    .res   (div_res)
  );

  assign limit  = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign clip   = div_res.big || (div_res.quot > limit);
  assign q_clip = clip ? limit : div_res.quot;

  assign diff_s  = signed'({raw_r[31], raw_r}) - signed'({avg_r[31], avg_r});
  assign sh_s    = diff_s >>> alpha_r;
  assign avg_new = avg_r + sh_s[31:0];

  assign mag      = avg_tmp_r[31] ? (~avg_tmp_r + 1'b1) : avg_tmp_r;
  assign avg_snap = (dzero_r && (mag < {1'b0, deadband_r})) ? '0 : avg_tmp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ewvf_pkg::S_IDLE;
      wr_idx_r    <= '0;
      fill_r      <= '0;
      avg_r       <= '0;
      deg_r       <= ewvf_pkg::DEG_PER_COUNT_RST;
      alpha_r     <= ewvf_pkg::ALPHA_SHIFT_RST;
      deadband_r  <= ewvf_pkg::DEADBAND_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          ewvf_pkg::REG_DEG_PER_COUNT: deg_r      <= pwdata;
          ewvf_pkg::REG_ALPHA_SHIFT:   alpha_r    <= pwdata[2:0];
          ewvf_pkg::REG_DEADBAND:      deadband_r <= pwdata[30:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && (state_r != ewvf_pkg::S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ewvf_pkg::S_IDLE: begin
          if (in_fire) begin
            if (in_op == ewvf_pkg::OP_FLUSH) begin
              wr_idx_r <= '0;
              fill_r   <= '0;
              avg_r    <= '0;
              state_r  <= ewvf_pkg::S_OUT;
            end else begin
              wr_idx_r <= wr_idx_nxt;
              fill_r   <= fill_nxt;
              state_r  <= ewvf_pkg::S_DIFF;
            end
          end
        end
        ewvf_pkg::S_DIFF: begin
          if ((fill_r > ewvf_pkg::CNT_W'(1)) && (dt_now != '0)) begin
            state_r <= ewvf_pkg::S_MUL;
          end else begin
            state_r <= ewvf_pkg::S_OUT;
          end
        end
        ewvf_pkg::S_MUL:   state_r <= ewvf_pkg::S_SCALE;
        ewvf_pkg::S_SCALE: state_r <= ewvf_pkg::S_LOAD;
        ewvf_pkg::S_LOAD:  state_r <= ewvf_pkg::S_DIV;
        ewvf_pkg::S_DIV: begin
          if (div_res.done) begin
            state_r <= ewvf_pkg::S_AVG;
          end
        end
        ewvf_pkg::S_AVG:   state_r <= ewvf_pkg::S_SNAP;
        ewvf_pkg::S_SNAP: begin
          avg_r   <= avg_snap;
          state_r <= ewvf_pkg::S_OUT;
        end
        ewvf_pkg::S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ewvf_pkg::S_IDLE;
          end
        end
        default: state_r <= ewvf_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ewvf_pkg::S_IDLE: begin
        if (in_fire) begin
          cnt_r     <= in_encoder_count;
          now_r     <= in_now_ms;
          res_upd_r <= (in_op == ewvf_pkg::OP_FLUSH);
          res_sat_r <= 1'b0;
        end
      end
      ewvf_pkg::S_DIFF: begin
        neg_r   <= d_now[31];
        m_r     <= d_now[31] ? (~d_now + 1'b1) : d_now;
        dzero_r <= (d_now == '0);
        dt_r    <= dt_now;
      end
      ewvf_pkg::S_MUL:   p_r   <= prod;
      ewvf_pkg::S_SCALE: num_r <= scaled[70:5];
      ewvf_pkg::S_DIV: begin
        if (div_res.done) begin
          sat_r <= clip;
          raw_r <= neg_r ? (~q_clip + 1'b1) : q_clip;
        end
      end
      ewvf_pkg::S_AVG:   avg_tmp_r <= avg_new;
      ewvf_pkg::S_SNAP: begin
        res_upd_r <= 1'b1;
        res_sat_r <= sat_r;
      end
      ewvf_pkg::S_OUT: begin
        if (out_free) begin
          out_velocity_r  <= avg_r;
          out_updated_r   <= res_upd_r;
          out_saturated_r <= res_sat_r;
        end
      end
      default: ;
    endcase
  end

  `EWVF_ASSERT_IMPL(a_fill_range, 1'b1,
    fill_r <= ewvf_pkg::CNT_W'(ewvf_pkg::WINDOW), "fill count above window")
  `EWVF_ASSERT_IMPL(a_idx_range, 1'b1,
    wr_idx_r < ewvf_pkg::IDX_W'(ewvf_pkg::WINDOW), "write index out of ring")
  `EWVF_ASSERT_IMPL(a_div_done, div_res.done,
    state_r == ewvf_pkg::S_DIV, "divider done outside divide step")
  `EWVF_ASSERT_NEXT(a_flush_clear, in_fire && (in_op == ewvf_pkg::OP_FLUSH),
    (fill_r == '0) && (avg_r == '0) && (state_r == ewvf_pkg::S_OUT),
    "flush did not clear history")

endmodule
